/* hdl/stt_pkg.sv */
package stt_pkg;

  localparam longint unsigned MAX_SOURCE_BYTES_DEF = 64'd1048576;
  localparam int unsigned     OFFSET_W             = 20;
  localparam int unsigned     LEN_W                = 21;
  localparam int unsigned     MAX_RESULTS          = 3;
  localparam logic [LEN_W-1:0] LINE_CAP            = 21'd1048576;

  localparam logic [5:0] K_DOT         = 6'd7;
  localparam logic [5:0] K_STRING      = 6'd22;
  localparam logic [5:0] K_NUMBER      = 6'd23;
  localparam logic [5:0] K_IDENT       = 6'd24;
  localparam logic [5:0] K_KEY0        = 6'd25;
  localparam logic [5:0] K_END         = 6'd44;
  localparam logic [5:0] K_ERR_CHAR    = 6'd45;
  localparam logic [5:0] K_ERR_COMMENT = 6'd46;
  localparam logic [5:0] K_ERR_STRING  = 6'd47;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_req;
  } in_t;

  typedef struct packed {
    logic [5:0]          kind;
    logic [OFFSET_W-1:0] start_offset;
    logic [LEN_W-1:0]    length;
    logic [LEN_W-1:0]    line_number;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [1:0] count;
    out_t [MAX_RESULTS-1:0] res;
  } batch_t;

  typedef struct packed {
    logic [47:0] text;
    logic [2:0]  len;
  } kw_t;

  function automatic kw_t keyword(input logic [4:0] idx);
    kw_t k;
    k = '0;
    case (idx)
      5'd0:  k = '{48'h616e64, 3'd3};       // and
      5'd1:  k = '{48'h6966, 3'd2};         // if
      5'd2:  k = '{48'h6f72, 3'd2};         // or
      5'd3:  k = '{48'h656c7365, 3'd4};     // else
      5'd4:  k = '{48'h656c6966, 3'd4};     // elif
      5'd5:  k = '{48'h666f72, 3'd3};       // for
      5'd6:  k = '{48'h7768696c65, 3'd5};   // while
      5'd7:  k = '{48'h627265616b, 3'd5};   // break
      5'd8:  k = '{48'h72657475726e, 3'd6}; // return
      5'd9:  k = '{48'h74727565, 3'd4};     // true
      5'd10: k = '{48'h66616c7365, 3'd5};   // false
      5'd11: k = '{48'h636c617373, 3'd5};   // class
      5'd12: k = '{48'h74686973, 3'd4};     // this
      5'd13: k = '{48'h66756e63, 3'd4};     // func
      5'd14: k = '{48'h7a696c, 3'd3};       // zil
      5'd15: k = '{48'h7072696e74, 3'd5};   // print
      5'd16: k = '{48'h766172, 3'd3};       // var
      5'd17: k = '{48'h73746174, 3'd4};     // stat
      5'd18: k = '{48'h64796e616d, 3'd5};   // dynam
      default: k = '{48'h0, 3'd0};
    endcase
    return k;
  endfunction

  function automatic logic [5:0] word_kind(input logic [47:0] buf_v, input logic [2:0] len_v);
    logic [5:0] k;
    kw_t        e;
    k = K_IDENT;
    for (int i = 18; i >= 0; i--) begin
      e = keyword(5'(i));
      if (e.len == len_v && e.text == buf_v) k = K_KEY0 + 6'(i);
    end
    return k;
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd5:    c = "+";
      3'd6:    c = "-";
      default: c = "=";
    endcase
    return c;
  endfunction

  function automatic logic [5:0] op_kind(input logic [2:0] p);
    return 6'd8 + {2'b00, p, 1'b0};
  endfunction

endpackage

/* hdl/stt_scanner.sv */
module stt_scanner #(
  parameter longint unsigned MAX_SOURCE_BYTES = stt_pkg::MAX_SOURCE_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  stt_pkg::in_t   item_i,
  output stt_pkg::batch_t batch_o
);
  import stt_pkg::*;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_OP      = 3'd1;
  localparam logic [2:0] M_COMMENT = 3'd2;
  localparam logic [2:0] M_STRING  = 3'd3;
  localparam logic [2:0] M_INT     = 3'd4;
  localparam logic [2:0] M_DOT     = 3'd5;
  localparam logic [2:0] M_FRAC    = 3'd6;
  localparam logic [2:0] M_IDENT   = 3'd7;

  localparam logic [LEN_W-1:0] POS_CAP =
    (MAX_SOURCE_BYTES < 64'd1048576) ? LEN_W'(MAX_SOURCE_BYTES) : LEN_W'(1048576);
  localparam logic [OFFSET_W-1:0] OFF_MAX = OFFSET_W'(POS_CAP - 21'd1);

  logic [2:0]          mode_q, mode_d;
  logic [2:0]          pend_q, pend_d;
  logic [OFFSET_W-1:0] tok_q, tok_d;
  logic [LEN_W-1:0]    pos_q, pos_d;
  logic [LEN_W-1:0]    line_q, line_d;
  logic [LEN_W-1:0]    cline_q, cline_d;
  logic [47:0]         word_q, word_d;
  logic [2:0]          wlen_q, wlen_d;

  batch_t              b;
  logic [7:0]          c;
  logic [OFFSET_W-1:0] off;
  logic [LEN_W-1:0]    after;
  logic [LEN_W-1:0]    tok_x;
  logic [OFFSET_W-1:0] dot;
  logic                fresh;
  logic                is_dig;
  logic                is_alp;
  logic [5:0]          sk;
  logic                sk_hit;

  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    tok_d   = tok_q;
    pos_d   = pos_q;
    line_d  = line_q;
    cline_d = cline_q;
    word_d  = word_q;
    wlen_d  = wlen_q;
    b       = '0;
    fresh   = 1'b0;
    sk      = '0;
    sk_hit  = 1'b0;
    c       = item_i.byte_req;
    tok_x   = {1'b0, tok_q};
    dot     = word_q[OFFSET_W-1:0];
    is_dig  = (c >= "0") && (c <= "9");
    is_alp  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    if (pos_q < POS_CAP) begin
      off   = pos_q[OFFSET_W-1:0];
      after = pos_q + 21'd1;
    end else begin
      off   = OFF_MAX;
      after = POS_CAP;
    end

    if (!item_i.action) begin
      pos_d = after;
      case (mode_q)
        M_OP: begin
          if (pend_q >= 3'd1 && pend_q <= 3'd6) begin
            if (c == op_second(pend_q)) begin
              b.res[b.count] = '{op_kind(pend_q) + 6'd1, tok_q, after - tok_x, line_q, 1'b0};
              b.count = b.count + 2'd1;
            end else begin
              b.res[b.count] = '{op_kind(pend_q), tok_q, 21'd1, line_q, 1'b0};
              b.count = b.count + 2'd1;
              fresh = 1'b1;
            end
          end else begin
            fresh = 1'b1;
          end
          mode_d = M_IDLE; pend_d = '0; word_d = '0; wlen_d = '0;
        end
        M_COMMENT: begin
          if (c == "$") begin
            mode_d = M_IDLE; pend_d = '0; word_d = '0; wlen_d = '0;
          end else if (c == "\n" && line_q < LINE_CAP) begin
            line_d = line_q + 21'd1;
          end
        end
        M_STRING: begin
          if (c == "\"") begin
            b.res[b.count] = '{K_STRING, tok_q, after - tok_x, line_q, 1'b0};
            b.count = b.count + 2'd1;
            mode_d = M_IDLE; pend_d = '0; word_d = '0; wlen_d = '0;
          end else if (c == "\n" && line_q < LINE_CAP) begin
            line_d = line_q + 21'd1;
          end
        end
        M_INT, M_FRAC: begin
          if (!is_dig) begin
            if (c == "." && mode_q == M_INT) begin
              mode_d = M_DOT;
              word_d = {28'd0, off};
            end else begin
              b.res[b.count] = '{K_NUMBER, tok_q, {1'b0, off} - tok_x, line_q, 1'b0};
              b.count = b.count + 2'd1;
              mode_d = M_IDLE; pend_d = '0; word_d = '0; wlen_d = '0;
              fresh = 1'b1;
            end
          end
        end
        M_DOT: begin
          if (is_dig) begin
            mode_d = M_FRAC;
            word_d = '0;
          end else begin
            b.res[b.count] = '{K_NUMBER, tok_q, {1'b0, dot} - tok_x, line_q, 1'b0};
            b.count = b.count + 2'd1;
            b.res[b.count] = '{K_DOT, dot, 21'd1, line_q, 1'b0};
            b.count = b.count + 2'd1;
            mode_d = M_IDLE; pend_d = '0; word_d = '0; wlen_d = '0;
            fresh = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alp || is_dig) begin
            if (wlen_q < 3'd6) begin
              word_d = {word_q[39:0], c};
              wlen_d = wlen_q + 3'd1;
            end else begin
              wlen_d = 3'd7;
            end
          end else begin
            b.res[b.count] = '{word_kind(word_q, wlen_q), tok_q, {1'b0, off} - tok_x,
                               line_q, 1'b0};
            b.count = b.count + 2'd1;
            mode_d = M_IDLE; pend_d = '0; word_d = '0; wlen_d = '0;
            fresh = 1'b1;
          end
        end
        default: begin
          mode_d = M_IDLE; pend_d = '0; word_d = '0; wlen_d = '0;
          fresh = 1'b1;
        end
      endcase

      if (fresh) begin
        sk_hit = 1'b1;
        sk     = '0;
        case (c)
          "(": sk = 6'd0;
          ")": sk = 6'd1;
          "[": sk = 6'd2;
          "]": sk = 6'd3;
          "{": sk = 6'd4;
          "}": sk = 6'd5;
          ",": sk = 6'd6;
          ".": sk = 6'd7;
          ";": sk = 6'd8;
          "*": sk = 6'd9;
          default: sk_hit = 1'b0;
        endcase
        if (sk_hit) begin
          b.res[b.count] = '{sk, off, 21'd1, line_q, 1'b0};
          b.count = b.count + 2'd1;
        end else begin
          case (c)
            "!", "=", "<", ">", "+", "-": begin
              mode_d = M_OP;
              tok_d  = off;
              case (c)
                "!":     pend_d = 3'd1;
                "=":     pend_d = 3'd2;
                "<":     pend_d = 3'd3;
                ">":     pend_d = 3'd4;
                "+":     pend_d = 3'd5;
                default: pend_d = 3'd6;
              endcase
            end
            " ", "\r", "\t": ;
            "\n": if (line_q < LINE_CAP) line_d = line_q + 21'd1;
            "$": begin
              mode_d  = M_COMMENT;
              tok_d   = off;
              cline_d = line_q;
            end
            "\"": begin
              mode_d = M_STRING;
              tok_d  = off;
            end
            default: begin
              if (is_dig) begin
                mode_d = M_INT;
                tok_d  = off;
              end else if (is_alp) begin
                mode_d = M_IDENT;
                tok_d  = off;
                word_d = {40'd0, c};
                wlen_d = 3'd1;
              end else begin
                b.res[b.count] = '{K_ERR_CHAR, off, 21'd1, line_q, 1'b0};
                b.count = b.count + 2'd1;
              end
            end
          endcase
        end
      end
    end else begin
      case (mode_q)
        M_OP: begin
          if (pend_q >= 3'd1 && pend_q <= 3'd6) begin
            b.res[b.count] = '{op_kind(pend_q), tok_q, 21'd1, line_q, 1'b0};
            b.count = b.count + 2'd1;
          end
        end
        M_COMMENT: begin
          b.res[b.count] = '{K_ERR_COMMENT, tok_q, pos_q - tok_x, cline_q, 1'b0};
          b.count = b.count + 2'd1;
        end
        M_STRING: begin
          b.res[b.count] = '{K_ERR_STRING, tok_q, pos_q - tok_x, line_q, 1'b0};
          b.count = b.count + 2'd1;
        end
        M_INT, M_FRAC: begin
          b.res[b.count] = '{K_NUMBER, tok_q, pos_q - tok_x, line_q, 1'b0};
          b.count = b.count + 2'd1;
        end
        M_DOT: begin
          b.res[b.count] = '{K_NUMBER, tok_q, {1'b0, dot} - tok_x, line_q, 1'b0};
          b.count = b.count + 2'd1;
          b.res[b.count] = '{K_DOT, dot, 21'd1, line_q, 1'b0};
          b.count = b.count + 2'd1;
        end
        M_IDENT: begin
          b.res[b.count] = '{word_kind(word_q, wlen_q), tok_q, pos_q - tok_x, line_q, 1'b0};
          b.count = b.count + 2'd1;
        end
        default: ;
      endcase
      b.res[b.count] = '{K_END, off, 21'd0, line_q, 1'b0};
      b.count = b.count + 2'd1;
      mode_d  = M_IDLE;
      pend_d  = '0;
      word_d  = '0;
      wlen_d  = '0;
      tok_d   = '0;
      pos_d   = '0;
      line_d  = 21'd1;
      cline_d = 21'd1;
    end

    if (b.count != 2'd0) b.res[b.count - 2'd1].last = 1'b1;
    batch_o = b;
    batch_o.count = accept_i ? b.count : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pend_q  <= '0;
      tok_q   <= '0;
      pos_q   <= '0;
      line_q  <= 21'd1;
      cline_q <= 21'd1;
      word_q  <= '0;
      wlen_q  <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      tok_q   <= tok_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      cline_q <= cline_d;
      word_q  <= word_d;
      wlen_q  <= wlen_d;
    end
  end

endmodule

/* hdl/stt_result_queue.sv */
module stt_result_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stt_pkg::batch_t batch_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output stt_pkg::out_t   out_data_o
);
  import stt_pkg::*;

  out_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign room_o      = (cnt_q <= 3'd1);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < batch_i.count) mem_q[wr_q + 2'(i)] <= batch_i.res[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + batch_i.count;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, batch_i.count} - {2'b00, pop};
    end
  end

endmodule

/* hdl/source_text_tokenizer.sv */
// A request's tokens are registered into the result queue when it is accepted.
// Throughput: one request per cycle unless in_stall_o; up to three tokens leave at one
// a cycle unless out_stall_i, via a four-entry result queue that stalls input while two or more wait.
// Reset: asynchronous active low; offset 0, line 1, queue empty.
module source_text_tokenizer #(
  parameter longint unsigned MAX_SOURCE_BYTES = stt_pkg::MAX_SOURCE_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  stt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output stt_pkg::out_t out_data_o
);
  import stt_pkg::*;

  batch_t batch;
  logic   room;
  logic   accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  stt_scanner #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
  ) u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .batch_o  (batch)
  );

  stt_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .batch_i     (batch),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/source_text_tokenizer_checker.sv */
module source_text_tokenizer_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  stt_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  stt_pkg::out_t out_data_i,
  output int            errors_o,
  output int            pending_o,
  output int            tokens_o
);
  import stt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_COMMENT, S_STRING, S_INT, S_DOT, S_FRAC, S_IDENT
  } mode_e;

  localparam logic [20:0] POS_CAP = 21'd1048576;

  out_t        token_q[$];
  mode_e       mode;
  logic [2:0]  op_pend;
  logic [19:0] tok_start;
  logic [20:0] pos;
  logic [20:0] lines;
  logic [20:0] cmt_line;
  logic [47:0] word;
  logic [2:0]  word_len;
  out_t        batch[$];

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] classify_word(logic [47:0] w, logic [2:0] n);
    string names[19] = '{"and", "if", "or", "else", "elif", "for", "while", "break",
                         "return", "true", "false", "class", "this", "func", "zil",
                         "print", "var", "stat", "dynam"};
    logic [47:0] packed_w;
    for (int i = 0; i < 19; i++) begin
      packed_w = '0;
      for (int j = 0; j < names[i].len(); j++) packed_w = {packed_w[39:0], names[i][j]};
      if (names[i].len() == n && packed_w == w) return K_KEY0 + 6'(i);
    end
    return K_IDENT;
  endfunction

  task automatic push_tok(logic [5:0] k, logic [20:0] s, logic [20:0] n, logic [20:0] l);
    out_t t;
    if (batch.size() >= 3) return;
    t.kind = k;
    t.start_offset = s[19:0];
    t.length = n;
    t.line_number = l;
    t.last = 1'b0;
    batch.push_back(t);
  endtask

  task automatic clear_word();
    mode = S_IDLE;
    op_pend = '0;
    word = '0;
    word_len = '0;
  endtask

  task automatic restart();
    clear_word();
    tok_start = '0;
    pos = '0;
    lines = 21'd1;
    cmt_line = 21'd1;
  endtask

  task automatic bump_line();
    if (lines < LINE_CAP) lines++;
  endtask

  task automatic begin_token(logic [7:0] c, logic [20:0] off, logic [20:0] nxt);
    logic [7:0] singles[10] = '{"(", ")", "[", "]", "{", "}", ",", ".", ";", "*"};
    logic [7:0] op_lead[6] = '{"!", "=", "<", ">", "+", "-"};
    for (int i = 0; i < 10; i++)
      if (c == singles[i]) begin
        push_tok(6'(i), off, nxt - off, lines);
        return;
      end
    for (int i = 0; i < 6; i++)
      if (c == op_lead[i]) begin
        mode = S_OP;
        op_pend = 3'(i + 1);
        tok_start = off[19:0];
        return;
      end
    if (c == " " || c == 8'h0d || c == 8'h09) return;
    if (c == 8'h0a) begin
      bump_line();
      return;
    end
    if (c == "$") begin
      mode = S_COMMENT;
      tok_start = off[19:0];
      cmt_line = lines;
    end else if (c == "\"") begin
      mode = S_STRING;
      tok_start = off[19:0];
    end else if (is_dig(c)) begin
      mode = S_INT;
      tok_start = off[19:0];
    end else if (is_alp(c)) begin
      mode = S_IDENT;
      tok_start = off[19:0];
      word = {40'd0, c};
      word_len = 3'd1;
    end else begin
      push_tok(K_ERR_CHAR, off, nxt - off, lines);
    end
  endtask

  task automatic predict_request(in_t req);
    logic [7:0]  c;
    logic [20:0] off, nxt, ts, dot;
    c = req.byte_req;
    ts = {1'b0, tok_start};
    batch.delete();
    if (!req.action) begin
      if (pos < POS_CAP) begin
        off = pos;
        nxt = pos + 21'd1;
      end else begin
        off = POS_CAP - 21'd1;
        nxt = POS_CAP;
      end
      pos = nxt;
      case (mode)
        S_OP:
          if (c == op_second(op_pend)) begin
            push_tok(op_kind(op_pend) + 6'd1, ts, nxt - ts, lines);
            clear_word();
          end else begin
            push_tok(op_kind(op_pend), ts, 21'd1, lines);
            clear_word();
            begin_token(c, off, nxt);
          end
        S_COMMENT:
          if (c == "$") clear_word();
          else if (c == 8'h0a) bump_line();
        S_STRING:
          if (c == "\"") begin
            push_tok(K_STRING, ts, nxt - ts, lines);
            clear_word();
          end else if (c == 8'h0a) begin
            bump_line();
          end
        S_INT:
          if (c == ".") begin
            mode = S_DOT;
            word = {28'd0, off[19:0]};
          end else if (!is_dig(c)) begin
            push_tok(K_NUMBER, ts, off - ts, lines);
            clear_word();
            begin_token(c, off, nxt);
          end
        S_DOT:
          if (is_dig(c)) begin
            mode = S_FRAC;
            word = '0;
          end else begin
            dot = {1'b0, word[19:0]};
            push_tok(K_NUMBER, ts, dot - ts, lines);
            push_tok(K_DOT, dot, 21'd1, lines);
            clear_word();
            begin_token(c, off, nxt);
          end
        S_FRAC:
          if (!is_dig(c)) begin
            push_tok(K_NUMBER, ts, off - ts, lines);
            clear_word();
            begin_token(c, off, nxt);
          end
        S_IDENT:
          if (is_alp(c) || is_dig(c)) begin
            if (word_len < 3'd6) begin
              word = {word[39:0], c};
              word_len++;
            end else begin
              word_len = 3'd7;
            end
          end else begin
            push_tok(classify_word(word, word_len), ts, off - ts, lines);
            clear_word();
            begin_token(c, off, nxt);
          end
        default: begin
          clear_word();
          begin_token(c, off, nxt);
        end
      endcase
    end else begin
      off = (pos < POS_CAP) ? pos : POS_CAP - 21'd1;
      case (mode)
        S_OP:      push_tok(op_kind(op_pend), ts, 21'd1, lines);
        S_COMMENT: push_tok(K_ERR_COMMENT, ts, pos - ts, cmt_line);
        S_STRING:  push_tok(K_ERR_STRING, ts, pos - ts, lines);
        S_INT, S_FRAC: push_tok(K_NUMBER, ts, pos - ts, lines);
        S_DOT: begin
          dot = {1'b0, word[19:0]};
          push_tok(K_NUMBER, ts, dot - ts, lines);
          push_tok(K_DOT, dot, 21'd1, lines);
        end
        S_IDENT:   push_tok(classify_word(word, word_len), ts, pos - ts, lines);
        default: ;
      endcase
      push_tok(K_END, off, 21'd0, lines);
      restart();
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) token_q.push_back(batch[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      restart();
      token_q.delete();
      errors_o <= 0;
      tokens_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        tokens_o <= tokens_o + 1;
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token %p", $time, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          want = token_q.pop_front();
          if (want !== out_data_i) begin
            $display("%0t: token mismatch: expected %p, got %p", $time, want, out_data_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_request(in_data_i);
    end
  end

  assign pending_o = token_q.size();
endmodule

/* tb/source_text_tokenizer_test.sv */
module source_text_tokenizer_test;
  import stt_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   errors, pending, tokens;
  int   send_idle = 0, recv_stall = 0;
  int   sent = 0;

  source_text_tokenizer uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  source_text_tokenizer_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending), .tokens_o(tokens)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stall, redrawn every falling edge
  always @(negedge clk_i) out_stall <= ($urandom_range(99) < recv_stall);

  // hold valid across back-to-back requests; drop it only for idle cycles
  task automatic send(logic act, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, byte_req: b};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(1'b0, s[i]);
  endtask

  // mostly well-formed lexemes, with noise bytes mixed in
  task automatic random_lexeme();
    string words[8] = '{"and", "return", "dynam", "zil", "while", "x_9", "abcdefgh", "Q"};
    string ops[10] = '{"!=", "==", "<=", ">=", "++", "--", "!", "=", "+", "-"};
    case ($urandom_range(9))
      0: send_text(words[$urandom_range(7)]);
      1: send_text(ops[$urandom_range(9)]);
      2: repeat ($urandom_range(1, 3)) send(1'b0, 8'("0") + 8'($urandom_range(9)));
      3: send_text($urandom_range(1) ? "3." : "4.5");
      4: send_text($urandom_range(1) ? "\"a\nb\"" : "$c\n$");
      5: send(1'b0, 8'($urandom_range(255)));
      6: send_text($urandom_range(1) ? " " : "\n");
      7: send_text("(){}[],.;*");
      8: if ($urandom_range(5) == 0) send(1'b1, 8'($urandom_range(255)));
         else send_text("\t");
      default: send_text(" ");
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: every operator, keywords, number forms, errors
    send_text("(){}[],.;*!!====<<=>>=+++--- ");
    send(1'b1, 8'h00);
    send_text("and return dynam zil 12.x 7.5\n\"s\n");
    send(1'b1, 8'hff);
    send_text("$open\n"); send(1'b0, 8'h00); send(1'b0, 8'hff);
    send(1'b1, 8'h00);
    send_text("12."); send(1'b1, 8'h00);
    send_text("ab_Z9xyzq"); send(1'b1, 8'h00);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 6) : 0;
      recv_stall = (ph == 2) ? 74 : ((ph == 3) ? 6 : 0);
      while (sent < 80 * (ph + 1) + 50) random_lexeme();
      send(1'b1, 8'h00);
    end
    in_valid <= 1'b0;
    send_idle = 0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests with all operators, keywords, numbers, strings,", sent);
    $display("comments and error bytes; checked %0d tokens under stall/idle phases.", tokens);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
